@@ sv/ccfd_pkg.sv @@
package ccfd_pkg;

  // Parser steps through the frame header and body.
  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_LEN_LO = 3'd1,
    ST_LEN_HI = 3'd2,
    ST_SEQ    = 3'd3,
    ST_HCRC   = 3'd4,
    ST_BODY   = 3'd5
  } parse_step_e;

  // Configuration register indexes and reset values.
  localparam int unsigned REG_START_BYTE = 0;
  localparam logic [7:0] START_BYTE_RST  = 8'hA5;

  // CRC seeds and reflected polynomials.
  localparam logic [7:0]  HDR_CRC_SEED = 8'hFF;
  localparam logic [7:0]  CRC8_POLY    = 8'h8C;
  localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY   = 16'h8408;

  // Reflected CRC8 update over one byte, bitwise.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC16 update over one byte, bitwise.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/ccfd_if.sv @@
// Received byte channel.
interface ccfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Deframer result channel.
interface ccfd_res_if;
  logic        valid;
  logic        ready;
  logic        out_is_verdict;
  logic        out_frame_ok;
  logic [15:0] out_command;
  logic [7:0]  out_sequence;
  logic [6:0]  out_length;
  logic [6:0]  out_offset;
  logic [7:0]  out_byte;

  modport source (
    output valid, output out_is_verdict, output out_frame_ok, output out_command,
    output out_sequence, output out_length, output out_offset, output out_byte,
    input ready
  );
  modport sink (
    input valid, input out_is_verdict, input out_frame_ok, input out_command,
    input out_sequence, input out_length, input out_offset, input out_byte,
    output ready
  );
endinterface

@@ sv/crc_checked_frame_deframer.sv @@
// A byte accepted into the input register is parsed there; any result it causes is loaded
// into the result register. Throughput: one byte per cycle while the result register is
// not stalled by res_o.ready; the CRC and parser update sets the rate.
// Reset (asynchronous, active low): parser returns to hunting for the start byte, the
// start byte register returns to 0xA5, and both pipeline registers are emptied.
module crc_checked_frame_deframer
  import ccfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccfd_rx_if.sink     rx_i,
  ccfd_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Accepted lengths stay below MAX_FRAME-7, byte counts reach length+8.
  localparam int unsigned LenLimit = MAX_FRAME - 7;
  localparam int unsigned LW = $clog2(MAX_FRAME);
  localparam int unsigned CW = $clog2(MAX_FRAME + 2);
  localparam logic [CW-1:0] CmdLoPos = CW'(5);
  localparam logic [CW-1:0] CmdHiPos = CW'(6);
  localparam logic [CW-1:0] BodyPos  = CW'(7);

  // Configuration register.
  logic [7:0] start_byte_q;
  logic       cfg_wr;
  logic       cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == 1'(REG_START_BYTE));
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? {24'h0, start_byte_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
    end else if (cfg_wr) begin
      start_byte_q <= pwdata[7:0];
    end
  end

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic       adv;

  assign adv        = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      in_byte_q <= 8'h00;
    end else if (rx_i.valid && rx_i.ready) begin
      in_vld_q  <= 1'b1;
      in_byte_q <= rx_i.rx_byte;
    end else if (adv) begin
      in_vld_q  <= 1'b0;
    end
  end

  // Parser state.
  parse_step_e    st_q, st_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [7:0]     len_lo_q, len_lo_d;
  logic [LW-1:0]  len_q, len_d;
  logic [7:0]     hcrc_q, hcrc_d;
  logic [15:0]    fcrc_q, fcrc_d;
  logic [7:0]     held_q, held_d;
  logic [15:0]    cmd_q, cmd_d;
  logic [7:0]     seq_q, seq_d;

  // Result of the current step.
  logic           emit;
  logic           res_verdict;
  logic           res_ok;
  logic [6:0]     res_offset;
  logic [7:0]     res_byte;

  logic [15:0]    len16;
  logic [CW-1:0]  body_end;
  logic [15:0]    off16;
  logic [15:0]    len_ext;

  assign len16    = {in_byte_q, len_lo_q};
  assign body_end = BodyPos + CW'(len_q);
  assign off16    = 16'(cnt_q) - 16'(BodyPos);
  assign len_ext  = 16'(len_q);

  // Next state and result for the byte in the input register.
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    len_lo_d    = len_lo_q;
    len_d       = len_q;
    hcrc_d      = hcrc_q;
    fcrc_d      = fcrc_q;
    held_d      = held_q;
    cmd_d       = cmd_q;
    seq_d       = seq_q;
    emit        = 1'b0;
    res_verdict = 1'b0;
    res_ok      = 1'b0;
    res_offset  = 7'd0;
    res_byte    = 8'h00;
    if (adv) begin
      unique case (st_q)
        ST_HUNT: begin
          if (in_byte_q == start_byte_q) begin
            hcrc_d = crc8_byte(HDR_CRC_SEED, in_byte_q);
            fcrc_d = crc16_byte(CRC16_INIT, in_byte_q);
            st_d   = ST_LEN_LO;
          end
        end
        ST_LEN_LO: begin
          len_lo_d = in_byte_q;
          hcrc_d   = crc8_byte(hcrc_q, in_byte_q);
          fcrc_d   = crc16_byte(fcrc_q, in_byte_q);
          st_d     = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          hcrc_d = crc8_byte(hcrc_q, in_byte_q);
          fcrc_d = crc16_byte(fcrc_q, in_byte_q);
          len_d  = len16[LW-1:0];
          // Oversized length drops the frame.
          st_d   = (len16 < 16'(LenLimit)) ? ST_SEQ : ST_HUNT;
        end
        ST_SEQ: begin
          seq_d  = in_byte_q;
          hcrc_d = crc8_byte(hcrc_q, in_byte_q);
          fcrc_d = crc16_byte(fcrc_q, in_byte_q);
          st_d   = ST_HCRC;
        end
        ST_HCRC: begin
          fcrc_d = crc16_byte(fcrc_q, in_byte_q);
          cnt_d  = CmdLoPos;
          // Header CRC mismatch drops the frame.
          st_d   = (hcrc_q == in_byte_q) ? ST_BODY : ST_HUNT;
        end
        ST_BODY: begin
          cnt_d = cnt_q + CW'(1);
          if (cnt_q < body_end) begin
            fcrc_d = crc16_byte(fcrc_q, in_byte_q);
          end
          priority if (cnt_q == CmdLoPos) begin
            cmd_d = {8'h00, in_byte_q};
          end else if (cnt_q == CmdHiPos) begin
            cmd_d = {in_byte_q, cmd_q[7:0]};
          end else if (cnt_q < body_end) begin
            emit       = 1'b1;
            res_offset = off16[6:0];
            res_byte   = in_byte_q;
          end else if (cnt_q == body_end) begin
            held_d = in_byte_q;
          end else begin
            // Last trailer byte: compare the stored CRC16 against the running one.
            emit        = 1'b1;
            res_verdict = 1'b1;
            res_ok      = (fcrc_q[7:0] == held_q) && (fcrc_q[15:8] == in_byte_q);
            st_d        = ST_HUNT;
          end
        end
        default: begin
          st_d = ST_HUNT;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_HUNT;
      cnt_q    <= '0;
      len_lo_q <= 8'h00;
      len_q    <= '0;
      hcrc_q   <= HDR_CRC_SEED;
      fcrc_q   <= CRC16_INIT;
      held_q   <= 8'h00;
      cmd_q    <= 16'h0000;
      seq_q    <= 8'h00;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      hcrc_q   <= hcrc_d;
      fcrc_q   <= fcrc_d;
      held_q   <= held_d;
      cmd_q    <= cmd_d;
      seq_q    <= seq_d;
    end
  end

  // Result register.
  logic        o_verdict_q;
  logic        o_ok_q;
  logic [15:0] o_cmd_q;
  logic [7:0]  o_seq_q;
  logic [6:0]  o_len_q;
  logic [6:0]  o_off_q;
  logic [7:0]  o_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      o_verdict_q <= res_verdict;
      o_ok_q      <= res_ok;
      o_cmd_q     <= cmd_q;
      o_seq_q     <= seq_q;
      o_len_q     <= len_ext[6:0];
      o_off_q     <= res_offset;
      o_byte_q    <= res_byte;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.out_is_verdict = o_verdict_q;
  assign res_o.out_frame_ok   = o_ok_q;
  assign res_o.out_command    = o_cmd_q;
  assign res_o.out_sequence   = o_seq_q;
  assign res_o.out_length     = o_len_q;
  assign res_o.out_offset     = o_off_q;
  assign res_o.out_byte       = o_byte_q;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import ccfd_pkg::*;

  localparam int unsigned MAX_FRAME      = 128;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam logic [2:0]  START_BYTE_ADDR = 3'(REG_START_BYTE * 4);

  // One deframer result as seen on the result channel.
  typedef struct packed {
    logic        is_verdict;
    logic        frame_ok;
    logic [15:0] command;
    logic [7:0]  seq_num;
    logic [6:0]  len7;
    logic [6:0]  offset;
    logic [7:0]  data;
  } deframe_result_t;

  // Shapes of frame that the traffic generator can build.
  typedef enum {
    FR_GOOD,
    FR_BAD_CRC16,
    FR_BAD_HCRC,
    FR_OVERSIZE
  } frame_kind_e;

  // Tracks the parser state of the deframer and holds the results it owes.
  class deframe_scoreboard;
    logic [7:0]  start_val;
    int unsigned max_frame;
    parse_step_e step;
    logic [7:0]  pos;
    logic [15:0] plen;
    logic [7:0]  hcrc;
    logic [15:0] fcrc;
    logic [7:0]  trailer_lo;
    logic [15:0] cmd;
    logic [7:0]  seq_num;
    deframe_result_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;

    function new(int unsigned max_frame_i);
      max_frame    = max_frame_i;
      start_val    = START_BYTE_RST;
      step         = ST_HUNT;
      pos          = '0;
      plen         = '0;
      hcrc         = HDR_CRC_SEED;
      fcrc         = CRC16_INIT;
      trailer_lo   = '0;
      cmd          = '0;
      seq_num      = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Reflected CRC8, one input bit at a time, LSB first.
    static function logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC8_POLY;
      end
      return c;
    endfunction

    // Reflected CRC16, one input bit at a time, LSB first.
    static function logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC16_POLY;
      end
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void go_hunt();
      step = ST_HUNT;
      pos  = '0;
    endfunction

    // Advance the parser by one accepted request byte and queue any result it causes.
    function void note_byte(input logic [7:0] b);
      deframe_result_t r;
      int unsigned     body_end;
      body_end = 7 + plen;
      r = '0;
      case (step)
        ST_HUNT: begin
          if (b == start_val) begin
            hcrc = crc8_next(HDR_CRC_SEED, b);
            fcrc = crc16_next(CRC16_INIT, b);
            pos  = 8'd1;
            step = ST_LEN_LO;
          end else begin
            pos = '0;
          end
        end
        ST_LEN_LO: begin
          plen = {8'h00, b};
          hcrc = crc8_next(hcrc, b);
          fcrc = crc16_next(fcrc, b);
          pos  = 8'd2;
          step = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          plen[15:8] = b;
          hcrc = crc8_next(hcrc, b);
          fcrc = crc16_next(fcrc, b);
          pos  = 8'd3;
          // A declared length that cannot fit drops the frame without a result.
          if (plen < max_frame - 7) step = ST_SEQ;
          else go_hunt();
        end
        ST_SEQ: begin
          seq_num = b;
          hcrc = crc8_next(hcrc, b);
          fcrc = crc16_next(fcrc, b);
          pos  = 8'd4;
          step = ST_HCRC;
        end
        ST_HCRC: begin
          fcrc = crc16_next(fcrc, b);
          pos  = 8'd5;
          if (hcrc == b) step = ST_BODY;
          else go_hunt();
        end
        ST_BODY: begin
          if (pos < body_end) fcrc = crc16_next(fcrc, b);
          if (pos == 5) begin
            cmd = {8'h00, b};
          end else if (pos == 6) begin
            cmd[15:8] = b;
          end else if (pos < body_end) begin
            // Payload bytes go out before the frame CRC is known.
            r.command = cmd;
            r.seq_num = seq_num;
            r.len7    = plen[6:0];
            r.offset  = 7'(pos - 7);
            r.data    = b;
            expected_q.push_back(r);
          end else if (pos == body_end) begin
            trailer_lo = b;
          end else begin
            r.is_verdict = 1'b1;
            r.frame_ok   = (fcrc[7:0] == trailer_lo) && (fcrc[15:8] == b);
            r.command    = cmd;
            r.seq_num    = seq_num;
            r.len7       = plen[6:0];
            expected_q.push_back(r);
            go_hunt();
          end
          if (step == ST_BODY) pos = pos + 8'd1;
        end
        default: go_hunt();
      endcase
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want) begin
        report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                  results_seen, name, got, want));
      end
    endtask

    // Compare one accepted result against the oldest outstanding prediction.
    task check_result(input deframe_result_t got);
      deframe_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
        return;
      end
      want = expected_q.pop_front();
      check_field("out_is_verdict", got.is_verdict, want.is_verdict);
      check_field("out_frame_ok", got.frame_ok, want.frame_ok);
      check_field("out_command", got.command, want.command);
      check_field("out_sequence", got.seq_num, want.seq_num);
      check_field("out_length", got.len7, want.len7);
      check_field("out_offset", got.offset, want.offset);
      check_field("out_byte", got.data, want.data);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        tx_valid_q = 1'b0;
  logic [7:0]  tx_byte_q = 8'h00;
  logic        take_ready_q = 1'b0;
  logic        psel_q = 1'b0;
  logic        penable_q = 1'b0;
  logic        pwrite_q = 1'b0;
  logic [2:0]  paddr_q = 3'd0;
  logic [31:0] pwdata_q = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_req = 0;
  int unsigned     hold_left = 0;
  logic [7:0]      cur_start = START_BYTE_RST;
  logic [7:0]      stream_q[$];
  deframe_result_t seen_result;
  deframe_scoreboard sb;

  ccfd_rx_if  rx ();
  ccfd_res_if res ();

  assign rx.valid   = tx_valid_q;
  assign rx.rx_byte = tx_byte_q;
  assign res.ready  = take_ready_q;

  crc_checked_frame_deframer #(
    .MAX_FRAME(MAX_FRAME)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res),
    .psel   (psel_q),
    .penable(penable_q),
    .pwrite (pwrite_q),
    .paddr  (paddr_q),
    .pwdata (pwdata_q),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Result side: check each accepted result, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst_ni) begin
      take_ready_q <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        seen_result.is_verdict = res.out_is_verdict;
        seen_result.frame_ok   = res.out_frame_ok;
        seen_result.command    = res.out_command;
        seen_result.seq_num    = res.out_sequence;
        seen_result.len7       = res.out_length;
        seen_result.offset     = res.out_offset;
        seen_result.data       = res.out_byte;
        sb.check_result(seen_result);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      // A long hold-off lets the deframer fill up and push back on its input.
      if (hold_left != 0) begin
        hold_left--;
        take_ready_q <= 1'b0;
      end else begin
        take_ready_q <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request byte, with random idle cycles first, and predict it on acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      tx_valid_q <= 1'b0;
      @(posedge clk);
    end
    tx_valid_q <= 1'b1;
    tx_byte_q  <= b;
    do @(posedge clk); while (!rx.ready);
    sb.note_byte(b);
  endtask

  task automatic send_queue();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic wait_drained();
    tx_valid_q <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel_q    <= 1'b1;
    penable_q <= 1'b0;
    pwrite_q  <= wr;
    paddr_q   <= addr;
    pwdata_q  <= wdata;
    @(posedge clk);
    penable_q <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    do @(posedge clk); while (!pready);
    psel_q    <= 1'b0;
    penable_q <= 1'b0;
    pwrite_q  <= 1'b0;
    @(posedge clk);
  endtask

  // Read back the current start byte, write a new one, and read it back again.
  task automatic config_start_byte(input logic [7:0] v);
    logic [31:0] rd;
    apb_access(1'b0, START_BYTE_ADDR, 32'h0, rd);
    sb.check_field("start_byte readback", rd[7:0], sb.start_val);
    apb_access(1'b1, START_BYTE_ADDR, {24'h0, v}, rd);
    sb.start_val = v;
    cur_start    = v;
    apb_access(1'b0, START_BYTE_ADDR, 32'h0, rd);
    sb.check_field("start_byte readback", rd[7:0], sb.start_val);
  endtask

  // Build one frame, whole or broken as asked, and queue its bytes.
  task automatic push_frame(input frame_kind_e kind, input logic [15:0] plen,
                            input logic [7:0] seq_b, input logic [15:0] cmd);
    logic [7:0]  fr[$];
    logic [7:0]  hc;
    logic [15:0] fc;
    fr.push_back(cur_start);
    fr.push_back(plen[7:0]);
    fr.push_back(plen[15:8]);
    if (kind != FR_OVERSIZE) begin
      fr.push_back(seq_b);
      hc = HDR_CRC_SEED;
      foreach (fr[i]) hc = deframe_scoreboard::crc8_next(hc, fr[i]);
      if (kind == FR_BAD_HCRC) hc = hc ^ 8'($urandom_range(1, 255));
      fr.push_back(hc);
      if (kind != FR_BAD_HCRC) begin
        fr.push_back(cmd[7:0]);
        fr.push_back(cmd[15:8]);
        repeat (plen) fr.push_back(8'($urandom_range(255)));
        fc = CRC16_INIT;
        foreach (fr[i]) fc = deframe_scoreboard::crc16_next(fc, fr[i]);
        if (kind == FR_BAD_CRC16) fc = fc ^ 16'($urandom_range(1, 65535));
        fr.push_back(fc[7:0]);
        fr.push_back(fc[15:8]);
      end
    end
    foreach (fr[i]) stream_q.push_back(fr[i]);
  endtask

  // Mostly well-formed frames with short payloads; the rest broken frames and line noise.
  task automatic make_traffic(input int unsigned n_bytes);
    int unsigned pick;
    int unsigned lsel;
    logic [15:0] plen;
    while (stream_q.size() < n_bytes) begin
      pick = $urandom_range(99);
      lsel = $urandom_range(99);
      if (lsel < 70) plen = 16'($urandom_range(12));
      else if (lsel < 90) plen = 16'($urandom_range(13, 60));
      else if (lsel < 97) plen = 16'($urandom_range(61, 119));
      else plen = 16'd120;
      if (pick < 70) begin
        push_frame(FR_GOOD, plen, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (pick < 78) begin
        push_frame(FR_BAD_CRC16, plen, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (pick < 84) begin
        push_frame(FR_BAD_HCRC, plen, 8'($urandom_range(255)), 16'($urandom_range(65535)));
      end else if (pick < 90) begin
        if (lsel < 50) plen = 16'($urandom_range(121, 255));
        else plen = 16'($urandom_range(256, 65535));
        push_frame(FR_OVERSIZE, plen, 8'h00, 16'h0000);
      end else begin
        repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [7:0] v;
    sb = new(MAX_FRAME);
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: noise while hunting, empty frame with a bad trailer, a one-byte frame at
    // the field maxima, the smallest oversized length and a corrupted header CRC.
    config_start_byte(START_BYTE_RST);
    stream_q.push_back(8'h00);
    push_frame(FR_BAD_CRC16, 16'd0, 8'h00, 16'h0000);
    push_frame(FR_GOOD, 16'd1, 8'hFF, 16'hFFFF);
    push_frame(FR_OVERSIZE, 16'(MAX_FRAME - 7), 8'h00, 16'h0000);
    push_frame(FR_BAD_HCRC, 16'd2, 8'h5A, 16'h1234);
    send_queue();
    wait_drained();

    // Random phases, each setting a start byte and an idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: v = 8'h00;
        1: v = 8'hFF;
        3: v = START_BYTE_RST;
        default: v = 8'($urandom_range(255));
      endcase
      config_start_byte(v);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      if (ph == 0) hold_req = 400;
      make_traffic(75);
      send_queue();
      if (ph == 5) wait_drained();
      make_traffic(75);
      send_queue();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
